// ----- hw/rtl/bkst_pkg.sv -----
package bkst_pkg;

    // Fixed widths of the request and result fields
    localparam int KEY_IN_W = 32;
    localparam int CMD_W    = 2;
    localparam int TOTAL_W  = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_APPLY = 3'b100
    } seq_state_t;

    // Write controls from the sequencer to the slot store
    typedef struct packed {
        logic key_we;
        logic used_set;
        logic used_clr;
    } store_ctl_t;

    // One finished result
    typedef struct packed {
        logic               success;
        logic               full_refusal;
        logic [TOTAL_W-1:0] member_total;
    } result_t;

endpackage

// ----- hw/rtl/bkst_store.sv -----
module bkst_store #(
    parameter int CAPACITY = 16,
    parameter int KW       = 32,
    parameter int IW       = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IW-1:0]         rd_addr,
    input  bkst_pkg::store_ctl_t  ctl,
    input  logic [IW-1:0]         wr_addr,
    input  logic [KW-1:0]         wr_key,
    output logic [KW-1:0]         rd_key,
    output logic                  rd_used
);
    import bkst_pkg::*;

    // Key storage; contents undefined until written, guarded by used bits
    logic [KW-1:0]       key_mem [CAPACITY];
    logic [KW-1:0]       rd_key_reg;
    logic [CAPACITY-1:0] used_reg;
    logic [CAPACITY-1:0] used_next;
    logic                rd_used_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.key_we)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        rd_key_reg <= key_mem[rd_addr];
    end

    always_comb
    begin
        used_next = used_reg;
        if (ctl.used_set)
        begin
            used_next[wr_addr] = 1'b1;
        end
        if (ctl.used_clr)
        begin
            used_next[wr_addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            rd_used_reg <= 1'b0;
        end
        else
        begin
            used_reg    <= used_next;
            rd_used_reg <= used_reg[rd_addr];
        end
    end

    assign rd_key  = rd_key_reg;
    assign rd_used = rd_used_reg;

endmodule

// ----- hw/rtl/bkst_seq.sv -----
module bkst_seq #(
    parameter int CAPACITY = 16,
    parameter int KW       = 32,
    parameter int IW       = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bkst_pkg::CMD_W-1:0]    cmd,
    input  logic [bkst_pkg::KEY_IN_W-1:0] key,
    input  logic                          out_busy,
    output logic                          res_load,
    output bkst_pkg::result_t             res,
    output logic [IW-1:0]                 rd_addr,
    input  logic [KW-1:0]                 rd_key,
    input  logic                          rd_used,
    output bkst_pkg::store_ctl_t          ctl,
    output logic [IW-1:0]                 wr_addr,
    output logic [KW-1:0]                 wr_key
);
    import bkst_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    seq_state_t        state_reg, state_next;
    logic [IW:0]       issue_reg, issue_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [IW-1:0]     chk_idx_reg, chk_idx_next;
    logic              hit_reg, hit_next;
    logic [IW-1:0]     hit_idx_reg, hit_idx_next;
    logic              free_reg, free_next;
    logic [IW-1:0]     free_idx_reg, free_idx_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [KW-1:0]     key_reg, key_next;
    logic              ok;
    logic              full;

    always_comb
    begin
        state_next    = state_reg;
        issue_next    = issue_reg;
        chk_vld_next  = 1'b0;
        chk_idx_next  = chk_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        cnt_next      = cnt_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        ok            = 1'b0;
        full          = 1'b0;
        res_load      = 1'b0;
        ctl           = '0;
        wr_addr       = hit_idx_reg;
        in_ready      = 1'b0;

        // shared comparator: one slot per cycle, on the registered read data
        if (chk_vld_reg)
        begin
            if (rd_used && (rd_key == key_reg))
            begin
                hit_next     = 1'b1;
                hit_idx_next = chk_idx_reg;
            end
            if (!rd_used && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = chk_idx_reg;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    key_next   = key[KW-1:0];
                    issue_next = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue_reg == (IW+1)'(CAPACITY))
                begin
                    state_next = ST_APPLY;
                end
                else
                begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = issue_reg[IW-1:0];
                    issue_next   = issue_reg + 1'b1;
                end
            end
            ST_APPLY:
            begin
                if (!out_busy)
                begin
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            if (!hit_reg)
                            begin
                                if (free_reg)
                                begin
                                    ctl.key_we   = 1'b1;
                                    ctl.used_set = 1'b1;
                                    wr_addr      = free_idx_reg;
                                    cnt_next     = cnt_reg + 1'b1;
                                    ok           = 1'b1;
                                end
                                else
                                begin
                                    full = 1'b1;
                                end
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (hit_reg)
                            begin
                                ctl.used_clr = 1'b1;
                                wr_addr      = hit_idx_reg;
                                if (cnt_reg != '0)
                                begin
                                    cnt_next = cnt_reg - 1'b1;
                                end
                                ok = 1'b1;
                            end
                        end
                        CMD_QUERY:
                        begin
                            ok = hit_reg;
                        end
                        default:
                        begin
                            ok = 1'b0;
                        end
                    endcase
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_addr          = issue_reg[IW-1:0];
    assign wr_key           = key_reg;
    assign res.success      = ok;
    assign res.full_refusal = full;
    assign res.member_total = TOTAL_W'(cnt_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            issue_reg   <= '0;
            chk_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            issue_reg   <= issue_next;
            chk_vld_reg <= chk_vld_next;
            hit_reg     <= hit_next;
            free_reg    <= free_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= chk_idx_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
    end

endmodule

// ----- hw/rtl/bounded_key_set_table_unit.sv -----
// Bounded key set table: holds up to CAPACITY unique keys.
// Request channel (in_valid/in_ready): cmd and key. cmd 0 inserts an absent
// key into the lowest free slot, 1 removes a present key, 2 queries
// membership; code 3 changes nothing. Only the low KEY_WIDTH bits of key
// (at most 32) are stored and compared.
// Result channel (out_valid/out_ready): success, member_total (count after
// the request, low 5 bits) and full_refusal (insert of an absent key
// refused because every slot is in use).
// The single key comparator walks the slot memory one slot per cycle
// through its registered read port; a last scan step drains the compare
// stage, then the apply state applies the update and loads the result
// and the sequencer returns to idle.
// Reset clears all used bits and the member count; slot keys stay
// undefined until written. The result register lets a new request be
// taken while a result waits; that request then holds in its update cycle
// until the receiver takes the previous result.
module bounded_key_set_table_unit #(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bkst_pkg::CMD_W-1:0]     cmd,
    input  logic [bkst_pkg::KEY_IN_W-1:0]  key,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           success,
    output logic [bkst_pkg::TOTAL_W-1:0]   member_total,
    output logic                           full_refusal
);
    import bkst_pkg::*;

    // stored key width: the request key is 32 bits wide
    localparam int KW = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;
    localparam int IW = $clog2(CAPACITY);

    logic            out_valid_reg;
    result_t         res_reg;
    result_t         res;
    logic            res_load;
    logic            out_busy;
    logic [IW-1:0]   rd_addr;
    logic [IW-1:0]   wr_addr;
    logic [KW-1:0]   rd_key;
    logic [KW-1:0]   wr_key;
    logic            rd_used;
    store_ctl_t      ctl;

    // sequencer may finish only when the result register is free
    assign out_busy = out_valid_reg && !out_ready;

    bkst_seq #(
        .CAPACITY (CAPACITY),
        .KW       (KW),
        .IW       (IW)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .key      (key),
        .out_busy (out_busy),
        .res_load (res_load),
        .res      (res),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_used  (rd_used),
        .ctl      (ctl),
        .wr_addr  (wr_addr),
        .wr_key   (wr_key)
    );

    bkst_store #(
        .CAPACITY (CAPACITY),
        .KW       (KW),
        .IW       (IW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .ctl     (ctl),
        .wr_addr (wr_addr),
        .wr_key  (wr_key),
        .rd_key  (rd_key),
        .rd_used (rd_used)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign success      = res_reg.success;
    assign full_refusal = res_reg.full_refusal;
    assign member_total = res_reg.member_total;

endmodule
